>>> rtl/core/msbd_pkg.sv
// Types and constants shared by the multi-sender bit deserializer.
package msbd_pkg;

  localparam int SENDER_W = 22;
  localparam int BYTE_W   = 8;
  localparam int CNT_W    = 3;

  localparam logic [CNT_W-1:0]  CNT_LAST = 3'd7;
  localparam logic [BYTE_W-1:0] EOM_BYTE = 8'h00;

  typedef struct packed {
    logic [SENDER_W-1:0] sender_id;
    logic                bit_value;
  } in_t;

  typedef struct packed {
    logic [SENDER_W-1:0] out_sender;
    logic [BYTE_W-1:0]   data_byte;
    logic                end_of_message;
    logic                dropped;
  } out_t;

  typedef struct packed {
    logic valid;
    out_t data;
  } res_t;

endpackage

>>> rtl/core/msbd_in_reg.sv
// Input register holding one request for the slot table.
module msbd_in_reg
  import msbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  input  logic advance,
  output logic item_valid,
  output in_t  item
);

  logic valid;
  in_t  data;

  assign in_ready   = !valid || advance;
  assign item_valid = valid;
  assign item       = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

>>> rtl/core/msbd_slot_table.sv
// Sender slot table: parallel lookup, bit packing and slot update.
module msbd_slot_table
  import msbd_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  input  in_t  item,
  input  logic commit,
  output res_t result
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0]    slot_valid;
  logic [SENDER_W-1:0] slot_sender       [SLOTS];
  logic [BYTE_W-1:0]   slot_partial_byte [SLOTS];
  logic [CNT_W-1:0]    slot_bit_count    [SLOTS];

  logic              hit_found;
  logic              free_found;
  logic [IDX_W-1:0]  hit_idx;
  logic [IDX_W-1:0]  free_idx;
  logic [IDX_W-1:0]  sel_idx;
  logic              full;
  logic [BYTE_W-1:0] cur_byte;
  logic [CNT_W-1:0]  cur_cnt;
  logic [BYTE_W-1:0] new_byte;
  logic              last;

  always_comb begin
    hit_found  = 1'b0;
    free_found = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    for (int k = SLOTS - 1; k >= 0; k--) begin
      if (slot_valid[k] && (slot_sender[k] == item.sender_id)) begin
        hit_found = 1'b1;
        hit_idx   = IDX_W'(k);
      end
      if (!slot_valid[k]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(k);
      end
    end
  end

  assign sel_idx  = hit_found ? hit_idx : free_idx;
  assign full     = !hit_found && !free_found;
  assign cur_byte = hit_found ? slot_partial_byte[sel_idx] : '0;
  assign cur_cnt  = hit_found ? slot_bit_count[sel_idx] : '0;
  assign new_byte = cur_byte | (BYTE_W'(item.bit_value) << cur_cnt);
  assign last     = (cur_cnt == CNT_LAST);

  always_comb begin
    result.valid               = item_valid && (full || last);
    result.data.out_sender     = item.sender_id;
    result.data.data_byte      = full ? '0 : new_byte;
    result.data.end_of_message = !full && (new_byte == EOM_BYTE);
    result.data.dropped        = full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (commit && !full) begin
      slot_valid[sel_idx] <= !last || (new_byte != EOM_BYTE);
    end
  end

  always_ff @(posedge clk) begin
    if (commit && !full) begin
      slot_sender[sel_idx] <= item.sender_id;
      if (last) begin
        slot_partial_byte[sel_idx] <= '0;
        slot_bit_count[sel_idx]    <= '0;
      end else begin
        slot_partial_byte[sel_idx] <= new_byte;
        slot_bit_count[sel_idx]    <= cur_cnt + CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/msbd_out_reg.sv
// Result register parting the slot table from the output channel.
module msbd_out_reg
  import msbd_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  out_t result,
  input  logic load,
  output logic free,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic valid;
  out_t data;

  assign free      = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data <= result;
    end
  end

endmodule

>>> rtl/core/multi_sender_bit_deserializer.sv
// Top level of the multi-sender bit deserializer.
//
//   channel | direction | payload | handshake
//   in      | input     | in_t    | in_valid / in_ready
//   out     | output    | out_t   | out_valid / out_ready
//
// One bit request is taken per cycle unless a stalled result holds it back;
// each result passes the input register and then the result register.
// The rate is set by the combinational slot lookup and registered update.
// Reset clears all slots at once; no clearing pass follows.
// A stalled result holds the input register only when the waiting bit
// produces a result of its own.
module multi_sender_bit_deserializer
  import msbd_pkg::*;
#(
  parameter int SLOTS = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic item_valid;
  in_t  item;
  res_t result;
  logic free;
  logic advance;

  assign advance = item_valid && (!result.valid || free);

  msbd_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  msbd_slot_table #(
    .SLOTS (SLOTS)
  ) u_slot_table (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .commit     (advance),
    .result     (result)
  );

  msbd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .result    (result.data),
    .load      (advance && result.valid),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> rtl/core/msbd_checker.sv
// Port-level checker for the multi-sender bit deserializer, with its bind.
module msbd_checker
  import msbd_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or vanished");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown after reset");

  a_drop_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.dropped |->
      (out_data.data_byte == '0) && !out_data.end_of_message)
    else $error("dropped request carries data");

  a_eom_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.dropped |->
      out_data.end_of_message == (out_data.data_byte == EOM_BYTE))
    else $error("end of message flag disagrees with byte");

  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    !in_valid ##1 !in_valid ##1 !out_valid |=> !out_valid)
    else $error("result with no pending request");

endmodule

bind multi_sender_bit_deserializer msbd_checker u_msbd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> verif/multi_sender_bit_deserializer_tb.sv
// Self-checking testbench for the multi-sender bit deserializer: directed table plus random traffic.
`timescale 1ns / 1ps

module multi_sender_bit_deserializer_tb;
  import msbd_pkg::*;

  localparam int SLOTS        = 8;
  localparam int RANDOM_BITS  = 1026;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam out_t NO_RESULT  = '0;

  typedef struct packed {
    in_t  req;
    logic typed;
    out_t want;
  } row_t;

  localparam row_t DIRECTED [24] = '{
    '{'{22'h000000, 1'b0}, 1'b0, NO_RESULT},
    '{'{22'h3FFFFF, 1'b1}, 1'b0, NO_RESULT},
    '{'{22'h000001, 1'b1}, 1'b0, NO_RESULT},
    '{'{22'h000002, 1'b0}, 1'b0, NO_RESULT},
    '{'{22'h000004, 1'b1}, 1'b0, NO_RESULT},
    '{'{22'h000008, 1'b0}, 1'b0, NO_RESULT},
    '{'{22'h000010, 1'b1}, 1'b0, NO_RESULT},
    '{'{22'h000020, 1'b0}, 1'b0, NO_RESULT},
    '{'{22'h2AAAAA, 1'b1}, 1'b1, '{22'h2AAAAA, 8'h00, 1'b0, 1'b1}},
    '{'{22'h000000, 1'b0}, 1'b0, NO_RESULT},
    '{'{22'h000000, 1'b0}, 1'b0, NO_RESULT},
    '{'{22'h000000, 1'b0}, 1'b0, NO_RESULT},
    '{'{22'h000000, 1'b0}, 1'b0, NO_RESULT},
    '{'{22'h000000, 1'b0}, 1'b0, NO_RESULT},
    '{'{22'h000000, 1'b0}, 1'b0, NO_RESULT},
    '{'{22'h000000, 1'b0}, 1'b1, '{22'h000000, 8'h00, 1'b1, 1'b0}},
    '{'{22'h155555, 1'b1}, 1'b0, NO_RESULT},
    '{'{22'h3FFFFF, 1'b1}, 1'b0, NO_RESULT},
    '{'{22'h3FFFFF, 1'b1}, 1'b0, NO_RESULT},
    '{'{22'h3FFFFF, 1'b1}, 1'b0, NO_RESULT},
    '{'{22'h3FFFFF, 1'b1}, 1'b0, NO_RESULT},
    '{'{22'h3FFFFF, 1'b1}, 1'b0, NO_RESULT},
    '{'{22'h3FFFFF, 1'b1}, 1'b0, NO_RESULT},
    '{'{22'h3FFFFF, 1'b1}, 1'b1, '{22'h3FFFFF, 8'hFF, 1'b0, 1'b0}}
  };

  localparam logic [SENDER_W-1:0] ID_POOL [8] = '{
    22'h000000, 22'h3FFFFF, 22'h000001, 22'h200000,
    22'h15A5A5, 22'h2A5A5A, 22'h0F0F0F, 22'h30C30C
  };

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  logic                slot_live [SLOTS];
  logic [SENDER_W-1:0] slot_id   [SLOTS];
  logic [BYTE_W-1:0]   slot_acc  [SLOTS];
  logic [CNT_W-1:0]    slot_cnt  [SLOTS];
  bit                  closing   [SLOTS];

  out_t byte_queue [$];
  out_t want_res;
  int   mismatches = 0;
  bit   send_idle  = 1'b1;
  bit   recv_idle  = 1'b1;
  bit   hold_off   = 1'b0;

  multi_sender_bit_deserializer #(.SLOTS(SLOTS)) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit deserialize_bit(input in_t req, output out_t res);
    int hit;
    logic [BYTE_W-1:0] acc;
    hit = -1;
    res = NO_RESULT;
    for (int k = 0; k < SLOTS; k++)
      if (hit < 0 && slot_live[k] && slot_id[k] == req.sender_id) hit = k;
    if (hit < 0) begin
      for (int k = 0; k < SLOTS; k++)
        if (hit < 0 && !slot_live[k]) begin
          hit          = k;
          slot_live[k] = 1'b1;
          slot_id[k]   = req.sender_id;
          slot_acc[k]  = '0;
          slot_cnt[k]  = '0;
        end
      if (hit < 0) begin
        res = '{req.sender_id, 8'h00, 1'b0, 1'b1};
        return 1'b1;
      end
    end
    acc = slot_acc[hit] | ({{(BYTE_W-1){1'b0}}, req.bit_value} << slot_cnt[hit]);
    if (slot_cnt[hit] != CNT_LAST) begin
      slot_acc[hit] = acc;
      slot_cnt[hit] = slot_cnt[hit] + CNT_W'(1);
      return 1'b0;
    end
    slot_acc[hit] = '0;
    slot_cnt[hit] = '0;
    res = '{req.sender_id, acc, acc == EOM_BYTE, 1'b0};
    if (acc == EOM_BYTE) slot_live[hit] = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_bit(input in_t req, input logic typed, input out_t want);
    out_t guess;
    bit   got;
    while (send_idle && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    got = deserialize_bit(req, guess);
    if (typed) byte_queue.push_back(want);
    else if (got) byte_queue.push_back(guess);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s expected %0h got %0h", $time, what, want, got);
  endtask

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (byte_queue.size() == 0) begin
        flag_mismatch("unexpected result, sender", '0, 32'(out_data.out_sender));
      end else begin
        want_res = byte_queue.pop_front();
        if (want_res.out_sender !== out_data.out_sender)
          flag_mismatch("out_sender", 32'(want_res.out_sender),
                        32'(out_data.out_sender));
        if (want_res.data_byte !== out_data.data_byte)
          flag_mismatch("data_byte", 32'(want_res.data_byte),
                        32'(out_data.data_byte));
        if (want_res.end_of_message !== out_data.end_of_message)
          flag_mismatch("end_of_message", 32'(want_res.end_of_message),
                        32'(out_data.end_of_message));
        if (want_res.dropped !== out_data.dropped)
          flag_mismatch("dropped", 32'(want_res.dropped), 32'(out_data.dropped));
      end
    end
  end

  initial begin : receiver
    out_ready = 1'b0;
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ready <= !(recv_idle && $urandom_range(0, 99) < 16);
      @(posedge clk);
    end
  end

  initial begin : stimulus
    in_t req;
    int  live [$];
    int  pick;
    int  k;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    foreach (slot_live[i]) begin
      slot_live[i] = 1'b0;
      slot_id[i]   = '0;
      slot_acc[i]  = '0;
      slot_cnt[i]  = '0;
      closing[i]   = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) send_bit(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);

    for (int n = 0; n < RANDOM_BITS; n++) begin
      if (n == 300) hold_off = 1'b1;
      send_idle = !(n >= 600 && n < 800);
      recv_idle = send_idle;
      live.delete();
      foreach (slot_live[i]) if (slot_live[i]) live.push_back(i);
      pick = $urandom_range(0, 99);
      if (pick < 12 || live.size() == 0) begin
        // stray request: new sender or noise
        req.sender_id = $urandom_range(0, 1) ? SENDER_W'($urandom)
                                             : ID_POOL[$urandom_range(0, 7)];
        req.bit_value = 1'($urandom);
      end else begin
        k = live[$urandom_range(0, live.size() - 1)];
        if (slot_cnt[k] == '0) closing[k] = ($urandom_range(0, 2) == 0);
        req.sender_id = slot_id[k];
        req.bit_value = closing[k] ? 1'b0 : 1'($urandom);
      end
      send_bit(req, 1'b0, NO_RESULT);
    end
    in_valid <= 1'b0;

    while (byte_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin : watchdog
    #2ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/msbd_pkg.sv
rtl/core/msbd_in_reg.sv
rtl/core/msbd_slot_table.sv
rtl/core/msbd_out_reg.sv
rtl/core/multi_sender_bit_deserializer.sv
rtl/core/msbd_checker.sv
verif/multi_sender_bit_deserializer_tb.sv
